### src/buddy_page_allocator_macros.svh
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shared assertion shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BPA_ASSERT_NOW(lbl, ante, cons)
`define BPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Widths, codes, sequencer states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;
  localparam int PAGE_COUNT  = 4096;
  localparam int ORDER_COUNT = 11;
  localparam int PAGE_W      = 12;
  localparam int ORD_W       = 4;
  localparam int CNT_W       = 13;
  localparam int SWP_W       = ORDER_COUNT - 1;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_SEED  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOBLK = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DEC, S_FR_CHK, S_SEED, S_MG_RD, S_MG_CHK, S_REL_W,
    S_PUSH, S_PUSH_RD, S_PUSH_W1, S_PUSH_W2, S_ARM_RD, S_ARM_WR, S_SPLIT, S_FIN
  } st_t;

  typedef struct packed {
    st_t  st;
    logic take_in;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic bad;
    logic alloc_none;
    logic is_alloc;
    logic is_seed;
    logic ref_set;
    logic merge_ok;
    logic at_top;
    logic split_more;
    logic tgt_empty;
    logic sweep_last;
    logic clr_last;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

### src/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy page allocator controller
// Sequencer that steps the datapath through clear, alloc, free and seed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_page_allocator_macros.svh"
module bpa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire bpa_pkg::sts_t sts,
  output bpa_pkg::ctl_t      ctl
);
  bpa_pkg::st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpa_pkg::S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    ctl.st       = state_r;
    ctl.take_in  = 1'b0;
    ctl.load_out = 1'b0;
    case (state_r)
      bpa_pkg::S_CLR: begin
        if (sts.clr_last) state_nxt = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.take_in = 1'b1;
          state_nxt   = bpa_pkg::S_DEC;
        end
      end
      bpa_pkg::S_DEC: begin
        if (sts.bad) state_nxt = bpa_pkg::S_FIN;
        else if (sts.is_alloc)
          state_nxt = sts.alloc_none ? bpa_pkg::S_FIN : bpa_pkg::S_ARM_RD;
        else if (sts.is_seed) state_nxt = bpa_pkg::S_SEED;
        else state_nxt = bpa_pkg::S_FR_CHK;
      end
      bpa_pkg::S_FR_CHK: begin
        state_nxt = sts.ref_set ? bpa_pkg::S_MG_RD : bpa_pkg::S_FIN;
      end
      bpa_pkg::S_SEED: begin
        if (sts.sweep_last) state_nxt = bpa_pkg::S_MG_RD;
      end
      bpa_pkg::S_MG_RD: begin
        state_nxt = sts.at_top ? bpa_pkg::S_REL_W : bpa_pkg::S_MG_CHK;
      end
      bpa_pkg::S_MG_CHK: begin
        state_nxt = sts.merge_ok ? bpa_pkg::S_MG_RD : bpa_pkg::S_REL_W;
      end
      bpa_pkg::S_REL_W: state_nxt = bpa_pkg::S_PUSH;
      bpa_pkg::S_PUSH: begin
        if (!sts.tgt_empty) state_nxt = bpa_pkg::S_PUSH_RD;
        else state_nxt = sts.is_alloc ? bpa_pkg::S_SPLIT : bpa_pkg::S_FIN;
      end
      bpa_pkg::S_PUSH_RD: state_nxt = bpa_pkg::S_PUSH_W1;
      bpa_pkg::S_PUSH_W1: state_nxt = bpa_pkg::S_PUSH_W2;
      bpa_pkg::S_PUSH_W2: begin
        state_nxt = sts.is_alloc ? bpa_pkg::S_SPLIT : bpa_pkg::S_FIN;
      end
      bpa_pkg::S_ARM_RD: state_nxt = bpa_pkg::S_ARM_WR;
      bpa_pkg::S_ARM_WR: state_nxt = bpa_pkg::S_SPLIT;
      bpa_pkg::S_SPLIT: begin
        state_nxt = sts.split_more ? bpa_pkg::S_PUSH : bpa_pkg::S_FIN;
      end
      bpa_pkg::S_FIN: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = bpa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bpa_pkg::S_CLR;
    endcase
  end

  `BPA_ASSERT_NEXT(a_take_dec, in_tvalid && in_tready, state_r == bpa_pkg::S_DEC)
  `BPA_ASSERT_NOW(a_clr_exit, state_r == bpa_pkg::S_CLR && state_nxt == bpa_pkg::S_IDLE, sts.clr_last)
  `BPA_ASSERT_NEXT(a_fin_idle, state_r == bpa_pkg::S_FIN && sts.out_free, state_r == bpa_pkg::S_IDLE)
endmodule
`default_nettype wire

### src/bpa_datapath.sv
// ----------------------------------------------------------------------------
// Buddy page allocator datapath
// Page memories, free list heads and counts, walk registers, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_page_allocator_macros.svh"
module bpa_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bpa_pkg::ctl_t ctl,
  output bpa_pkg::sts_t      sts,
  input  wire logic [15:0]   in_tdata,
  input  wire logic [1:0]    in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [15:0]        out_tdata,
  output logic [1:0]         out_tuser
);
  localparam int PW = bpa_pkg::PAGE_W;
  localparam int OW = bpa_pkg::ORD_W;
  localparam int NO = bpa_pkg::ORDER_COUNT;

  logic                 free_mem  [bpa_pkg::PAGE_COUNT];
  logic [OW-1:0]        order_mem [bpa_pkg::PAGE_COUNT];
  logic                 ref_mem   [bpa_pkg::PAGE_COUNT];
  logic [PW-1:0]        next_mem  [bpa_pkg::PAGE_COUNT];
  logic [PW-1:0]        prev_mem  [bpa_pkg::PAGE_COUNT];

  logic [PW-1:0]        head_r [NO];
  logic [NO-1:0]        nonempty_r;
  logic [bpa_pkg::CNT_W-1:0] count_r [NO];

  logic [1:0]           cmd_r, status_r;
  logic [OW-1:0]        ord_r, o_r, cur_r, po_r, ro_r;
  logic [PW-1:0]        page_r, p_r, pp_r, t_r, rp_r, clr_r;
  logic [bpa_pkg::SWP_W-1:0] i_r;
  logic                 out_valid_r;
  logic [15:0]          out_data_r;
  logic [1:0]           out_user_r;

  logic                 free_rd_r, ref_rd_r;
  logic [OW-1:0]        order_rd_r;
  logic [PW-1:0]        next_rd_r, prev_rd_r;

  logic [PW-1:0]        raddr, buddy, half, rm_p;
  logic [OW-1:0]        rm_o, cur_m1, fcur;
  logic                 found, rm_do;
  logic [bpa_pkg::CNT_W-1:0] sz, sz_m1, span;

  logic                 free_we, order_we, ref_we, next_we, prev_we;
  logic [PW-1:0]        free_a, order_a, ref_a, next_a, prev_a;
  logic                 free_d, ref_d;
  logic [OW-1:0]        order_d;
  logic [PW-1:0]        next_d, prev_d;

  assign sz     = bpa_pkg::CNT_W'(1) << ord_r;
  assign sz_m1  = sz - bpa_pkg::CNT_W'(1);
  assign span   = {1'b0, page_r} + sz;
  assign buddy  = p_r ^ (PW'(1) << o_r);
  assign cur_m1 = cur_r - OW'(1);
  assign half   = p_r + (PW'(1) << cur_m1);

  always_comb begin
    found = 1'b0;
    fcur  = '0;
    for (int k = 0; k < NO; k++) begin
      if (!found && OW'(k) >= ord_r && nonempty_r[k]) begin
        found = 1'b1;
        fcur  = OW'(k);
      end
    end
  end

  always_comb begin
    sts.bad        = cmd_r == bpa_pkg::CMD_NONE || ord_r >= OW'(NO) ||
                     (cmd_r != bpa_pkg::CMD_ALLOC &&
                      ((page_r & sz_m1[PW-1:0]) != '0 ||
                       span > bpa_pkg::CNT_W'(bpa_pkg::PAGE_COUNT)));
    sts.alloc_none = !found;
    sts.is_alloc   = cmd_r == bpa_pkg::CMD_ALLOC;
    sts.is_seed    = cmd_r == bpa_pkg::CMD_SEED;
    sts.ref_set    = ref_rd_r;
    sts.merge_ok   = free_rd_r && order_rd_r == o_r;
    sts.at_top     = o_r == OW'(NO - 1);
    sts.split_more = cur_r > ord_r;
    sts.tgt_empty  = !nonempty_r[po_r];
    sts.sweep_last = i_r == sz_m1[bpa_pkg::SWP_W-1:0];
    sts.clr_last   = clr_r == '1;
    sts.out_free   = !out_valid_r || out_tready;
  end

  always_comb begin
    case (ctl.st)
      bpa_pkg::S_DEC:     raddr = page_r;
      bpa_pkg::S_MG_RD:   raddr = buddy;
      bpa_pkg::S_PUSH:    raddr = head_r[po_r];
      bpa_pkg::S_PUSH_RD: raddr = head_r[po_r];
      default:            raddr = p_r;
    endcase
    rm_o  = (ctl.st == bpa_pkg::S_ARM_WR) ? cur_r : o_r;
    rm_p  = (ctl.st == bpa_pkg::S_ARM_WR) ? p_r : buddy;
    rm_do = ctl.st == bpa_pkg::S_ARM_WR ||
            (ctl.st == bpa_pkg::S_MG_CHK && sts.merge_ok);
  end

  always_comb begin
    free_we = 1'b0; order_we = 1'b0; ref_we = 1'b0; next_we = 1'b0; prev_we = 1'b0;
    free_a = p_r; order_a = p_r; ref_a = p_r; next_a = pp_r; prev_a = pp_r;
    free_d = 1'b0; order_d = '0; ref_d = 1'b0; next_d = pp_r; prev_d = pp_r;
    if (rm_do && next_rd_r != rm_p) begin
      next_we = 1'b1; next_a = prev_rd_r; next_d = next_rd_r;
      prev_we = 1'b1; prev_a = next_rd_r; prev_d = prev_rd_r;
    end
    case (ctl.st)
      bpa_pkg::S_CLR: begin
        free_we = 1'b1; order_we = 1'b1; ref_we = 1'b1;
        free_a = clr_r; order_a = clr_r; ref_a = clr_r;
      end
      bpa_pkg::S_FR_CHK: begin
        ref_we = ref_rd_r; ref_a = page_r;
      end
      bpa_pkg::S_SEED: begin
        free_we = 1'b1; ref_we = 1'b1;
        free_a = page_r + PW'(i_r); ref_a = page_r + PW'(i_r);
      end
      bpa_pkg::S_MG_CHK: begin
        free_we = sts.merge_ok; order_we = sts.merge_ok;
        free_a = buddy; order_a = buddy;
      end
      bpa_pkg::S_REL_W: begin
        free_we = 1'b1; order_we = 1'b1; free_d = 1'b1; order_d = o_r;
      end
      bpa_pkg::S_PUSH: begin
        next_we = sts.tgt_empty; prev_we = sts.tgt_empty;
      end
      bpa_pkg::S_PUSH_W1: begin
        next_we = 1'b1; next_d = head_r[po_r];
        prev_we = 1'b1; prev_d = prev_rd_r;
      end
      bpa_pkg::S_PUSH_W2: begin
        next_we = 1'b1; next_a = t_r;
        prev_we = 1'b1; prev_a = head_r[po_r];
      end
      bpa_pkg::S_SPLIT: begin
        free_we = 1'b1; order_we = 1'b1;
        if (sts.split_more) begin
          free_a = half; order_a = half; free_d = 1'b1; order_d = cur_m1;
        end else begin
          order_d = ord_r; ref_we = 1'b1; ref_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_a] <= free_d;
    if (order_we) order_mem[order_a] <= order_d;
    if (ref_we) ref_mem[ref_a] <= ref_d;
    if (next_we) next_mem[next_a] <= next_d;
    if (prev_we) prev_mem[prev_a] <= prev_d;
    free_rd_r  <= free_mem[raddr];
    order_rd_r <= order_mem[raddr];
    ref_rd_r   <= ref_mem[raddr];
    next_rd_r  <= next_mem[raddr];
    prev_rd_r  <= prev_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r <= '0;
      for (int k = 0; k < NO; k++) count_r[k] <= '0;
    end else if (rm_do) begin
      if (next_rd_r == rm_p) nonempty_r[rm_o] <= 1'b0;
      else if (head_r[rm_o] == rm_p) head_r[rm_o] <= next_rd_r;
      if (count_r[rm_o] != '0) count_r[rm_o] <= count_r[rm_o] - bpa_pkg::CNT_W'(1);
    end else if ((ctl.st == bpa_pkg::S_PUSH && sts.tgt_empty) ||
                 ctl.st == bpa_pkg::S_PUSH_W2) begin
      head_r[po_r]     <= pp_r;
      nonempty_r[po_r] <= 1'b1;
      count_r[po_r]    <= count_r[po_r] + bpa_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.st == bpa_pkg::S_CLR) clr_r <= clr_r + PW'(1);
      if (ctl.load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      cmd_r  <= in_tuser;
      ord_r  <= in_tdata[3:0];
      page_r <= in_tdata[15:4];
    end
    if (ctl.load_out) begin
      out_data_r <= {ro_r, rp_r};
      out_user_r <= status_r;
    end
    case (ctl.st)
      bpa_pkg::S_DEC: begin
        rp_r <= '0;
        ro_r <= '0;
        i_r  <= '0;
        if (sts.bad) status_r <= bpa_pkg::ST_BAD;
        else if (sts.is_alloc && !found) status_r <= bpa_pkg::ST_NOBLK;
        else status_r <= bpa_pkg::ST_OK;
        if (sts.is_alloc) begin
          p_r   <= head_r[fcur];
          cur_r <= fcur;
        end else begin
          p_r <= page_r;
          o_r <= ord_r;
        end
      end
      bpa_pkg::S_FR_CHK: if (!ref_rd_r) status_r <= bpa_pkg::ST_DUP;
      bpa_pkg::S_SEED:   i_r <= i_r + bpa_pkg::SWP_W'(1);
      bpa_pkg::S_MG_CHK: begin
        if (sts.merge_ok) begin
          p_r <= p_r & buddy;
          o_r <= o_r + OW'(1);
        end
      end
      bpa_pkg::S_REL_W: begin
        pp_r <= p_r; po_r <= o_r; rp_r <= p_r; ro_r <= o_r;
      end
      bpa_pkg::S_PUSH_W1: t_r <= prev_rd_r;
      bpa_pkg::S_SPLIT: begin
        if (sts.split_more) begin
          cur_r <= cur_m1; pp_r <= half; po_r <= cur_m1;
        end else begin
          rp_r <= p_r; ro_r <= ord_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `BPA_ASSERT_NEXT(a_load_valid, ctl.load_out, out_valid_r)
  `BPA_ASSERT_NOW(a_err_zero, ctl.load_out && status_r != bpa_pkg::ST_OK, rp_r == '0 && ro_r == '0)
  `BPA_ASSERT_NOW(a_merge_below_top, ctl.st == bpa_pkg::S_MG_CHK, !sts.at_top)
endmodule
`default_nettype wire

### src/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// Buddy page allocator
// Power-of-two page blocks on per-order doubly linked free lists.
// ----------------------------------------------------------------------------
// A bad request or an empty pool goes straight to the result; a free checks for
// a double free, merges with free buddies of the same order up to the top order
// and links the block onto its list; a seed first clears the flags of each page
// of the block and then goes on as a free; an alloc unlinks a block and splits it.
// Requests: one at a time; the next can be taken in the cycle after the result loads.
// Reset: synchronous, active low; a clearing pass over all 4096 pages follows.
`timescale 1ns / 1ps
`default_nettype none
module buddy_page_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // block_order[3:0], page_index[15:4]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // result_page[11:0], result_order[15:12]
  output logic [1:0]       out_tuser   // status[1:0]
);
  bpa_pkg::ctl_t ctl;
  bpa_pkg::sts_t sts;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  bpa_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );
endmodule
`default_nettype wire
